// ===== sv/obdpid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OBD-II mode 01 PID decoder package
// PID codes, register indexes, scaling constants and shared types.
// ----------------------------------------------------------------------------
package obdpid_pkg;

   // Engineering value on the result channel.
   typedef logic signed [16:0] scaled_type;

   // Register index, taken from the word address of the configuration port.
   typedef logic csr_index_type;

   localparam csr_index_type CSR_SUPPORTED_MASK = 1'b0;
   localparam csr_index_type CSR_MASK_KNOWN     = 1'b1;

   // Decoded mode 01 PIDs.
   localparam logic [7:0] MODE01_STATUS      = 8'h01;
   localparam logic [7:0] MODE01_FUEL_SYSTEM = 8'h03;
   localparam logic [7:0] MODE01_ENGINE_LOAD = 8'h04;
   localparam logic [7:0] MODE01_COOLANT     = 8'h05;
   localparam logic [7:0] MODE01_SHORT_TRIM  = 8'h06;
   localparam logic [7:0] MODE01_LONG_TRIM   = 8'h07;
   localparam logic [7:0] MODE01_RPM         = 8'h0C;
   localparam logic [7:0] MODE01_SPEED       = 8'h0D;
   localparam logic [7:0] MODE01_TIMING      = 8'h0E;
   localparam logic [7:0] MODE01_INTAKE_TEMP = 8'h0F;
   localparam logic [7:0] MODE01_MAF         = 8'h10;
   localparam logic [7:0] MODE01_THROTTLE    = 8'h11;

   // Scaling constants.
   localparam int unsigned PCT_SCALE     = 1000;  // percent x10 full scale
   localparam int unsigned BYTE_FULL     = 255;   // full-scale byte value
   localparam int unsigned TEMP_OFFSET   = 40;    // degrees C offset
   localparam int unsigned TRIM_CENTRE   = 128;   // zero trim code
   localparam int unsigned TIMING_OFFSET = 640;   // timing offset in deg x10

endpackage

// ===== sv/obd_mode01_pid_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OBD-II mode 01 PID decoder
// Converts one mode 01 answer into a fixed-scale engineering value.
// ----------------------------------------------------------------------------
// Usage:
// The request channel carries one answer per transfer: PID number, data bytes
// A and B, the received byte count and an abandoned flag. The response channel
// returns one transfer per request: the scaled value and a valid flag. When the
// flag is low the value is zero.
// Two registers are written through the APB port: the PID 1..32 support
// bitmap at address 0 and the bitmap-known flag at address 4. Write them only
// while no request is in flight.
// The request is captured in the input register and its result in the result
// register, which drives the response channel. One request is taken every
// cycle while req_stall is low; the decode is a single pass between the input
// register and the result register.
// Reset clears both pipeline stages and both configuration registers. When the
// receiver stalls, the result register holds, the input register fills
// behind it, and req_stall rises once both stages are occupied.
// ----------------------------------------------------------------------------
module obd_mode01_pid_decoder_top
   import obdpid_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // Request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_pid_number,
   input  logic [7:0]              req_byte_a,
   input  logic [7:0]              req_byte_b,
   input  logic [3:0]              req_byte_count,
   input  logic                    req_cycle_abandoned,
   // Response channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [16:0]      rsp_scaled_value,
   output logic                    rsp_value_valid,
   // Configuration port
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [2:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   // Configuration registers
   logic [31:0]   supported_mask_ff;
   logic          mask_known_ff;
   logic          csr_write;
   csr_index_type csr_index;

   // Input stage
   logic          s1_valid_ff,  s1_valid_in;
   logic [7:0]    s1_pid_ff;
   logic [7:0]    s1_a_ff;
   logic [7:0]    s1_b_ff;
   logic [3:0]    s1_count_ff;
   logic          s1_abandoned_ff;
   logic          s1_load;

   // Result stage
   logic          s2_valid_ff,  s2_valid_in;
   scaled_type    s2_value_ff,  s2_value_in;
   logic          s2_ok_ff,     s2_ok_in;
   logic          s1_ready;
   logic          s2_ready;

   // Decode datapath
   logic [7:0]    pid_less_one;
   logic          pid_claimed;
   logic [17:0]   pct_prod;
   logic [25:0]   pct_recip;
   logic [9:0]    pct_est;
   logic [17:0]   pct_rem;
   logic [9:0]    pct_quot;
   logic signed [8:0]  trim_diff;
   logic signed [17:0] trim_prod;
   logic signed [17:0] trim_bias;
   logic signed [10:0] trim_quot;
   logic signed [8:0]  temp_value;
   logic [11:0]        timing_prod;
   logic signed [11:0] timing_value;
   logic [15:0]        word_ab;
   logic               base_ok;
   logic               two_bytes;

   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         supported_mask_ff <= '0;
         mask_known_ff     <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SUPPORTED_MASK: supported_mask_ff <= pwdata;
            CSR_MASK_KNOWN:     mask_known_ff     <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      unique case (csr_index)
         CSR_SUPPORTED_MASK: prdata = supported_mask_ff;
         CSR_MASK_KNOWN:     prdata = {31'b0, mask_known_ff};
         default:            prdata = '0;
      endcase
   end

   // Pipeline flow control: each stage moves when the one after it can take it.
   assign s2_ready  = !s2_valid_ff || !rsp_stall;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;
   assign s1_load   = req_valid && s1_ready;

   always_comb begin
      s1_valid_in = s1_ready ? req_valid : s1_valid_ff;
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Input register captures the request on each transfer.
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_pid_ff       <= req_pid_number;
         s1_a_ff         <= req_byte_a;
         s1_b_ff         <= req_byte_b;
         s1_count_ff     <= req_byte_count;
         s1_abandoned_ff <= req_cycle_abandoned;
      end
   end

   // Support check: PID 1 maps to bit 31 and PID 32 to bit 0.
   always_comb begin
      pid_less_one = s1_pid_ff - 8'd1;
      pid_claimed  = mask_known_ff && (s1_pid_ff != 8'd0) && (pid_less_one[7:5] == 3'd0)
                     && supported_mask_ff[~pid_less_one[4:0]];
      base_ok      = !s1_abandoned_ff && pid_claimed && (s1_count_ff != 4'd0);
      two_bytes    = (s1_count_ff[3:1] != 3'd0);
   end

   // Percent scaling A*1000/255. The quotient is first estimated with the
   // reciprocal 257/65536, which is never more than one short, then corrected
   // by a single compare on the remainder.
   always_comb begin
      pct_prod  = 18'(s1_a_ff) * 18'(PCT_SCALE);
      pct_recip = {pct_prod, 8'b0} + {8'b0, pct_prod};
      pct_est   = pct_recip[25:16];
      pct_rem   = pct_prod - {pct_est, 8'b0} + 18'(pct_est);
      pct_quot  = (pct_rem >= 18'(BYTE_FULL)) ? pct_est + 10'd1 : pct_est;
   end

   // Fuel trim (A-128)*1000/128, rounded toward zero by biasing negatives.
   always_comb begin
      trim_diff = $signed({1'b0, s1_a_ff}) - 9'sd128;
      trim_prod = 18'(trim_diff) * $signed(18'(PCT_SCALE));
      trim_bias = trim_prod + (trim_prod[17] ? 18'sd127 : 18'sd0);
      trim_quot = trim_bias[17:7];
   end

   // Temperatures, timing advance and the two-byte word.
   always_comb begin
      temp_value   = $signed({1'b0, s1_a_ff}) - $signed(9'(TEMP_OFFSET));
      timing_prod  = 12'(s1_a_ff) * 12'd5;
      timing_value = $signed(timing_prod) - $signed(12'(TIMING_OFFSET));
      word_ab      = {s1_a_ff, s1_b_ff};
   end

   // Select the scaling for the PID; anything not decoded reads as invalid.
   always_comb begin
      s2_ok_in    = base_ok;
      s2_value_in = '0;
      unique case (s1_pid_ff) inside
         MODE01_STATUS, MODE01_FUEL_SYSTEM, MODE01_SPEED:
            s2_value_in = scaled_type'(s1_a_ff);
         MODE01_ENGINE_LOAD, MODE01_THROTTLE:
            s2_value_in = scaled_type'(pct_quot);
         MODE01_COOLANT, MODE01_INTAKE_TEMP:
            s2_value_in = scaled_type'(temp_value);
         MODE01_SHORT_TRIM, MODE01_LONG_TRIM:
            s2_value_in = scaled_type'(trim_quot);
         MODE01_RPM: begin
            s2_value_in = scaled_type'(word_ab[15:2]);
            s2_ok_in    = base_ok && two_bytes;
         end
         MODE01_TIMING:
            s2_value_in = scaled_type'(timing_value);
         MODE01_MAF: begin
            s2_value_in = scaled_type'(word_ab);
            s2_ok_in    = base_ok && two_bytes;
         end
         default:
            s2_ok_in = 1'b0;
      endcase
      if (!s2_ok_in) begin
         s2_value_in = '0;
      end
   end

   // Result register holds while the receiver stalls.
   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_value_ff <= s2_value_in;
         s2_ok_ff    <= s2_ok_in;
      end
   end

   assign rsp_valid        = s2_valid_ff;
   assign rsp_scaled_value = s2_value_ff;
   assign rsp_value_valid  = s2_ok_ff;

   // An invalid result always carries a zero value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_value_valid |-> rsp_scaled_value == 17'sd0)
      else $error("Invalid result carries a non-zero value.");

   // A valid reading never falls below the lowest fuel trim.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_value_valid |-> rsp_scaled_value >= -17'sd1000)
      else $error("Decoded value below the lowest scale.");

   // The request side only stalls when both stages are full and blocked.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s2_valid_ff && rsp_stall)
      else $error("Request stalled with room in the pipeline.");

   // An abandoned cycle never yields a reading.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_abandoned_ff |-> !s2_ok_in)
      else $error("Abandoned cycle decoded as valid.");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("Pipeline not empty after reset.");

endmodule
